// File: src/sgh_pkg.sv
// Package for the wrapped housing-grid happiness checker.
// Holds kind and mode codes, register indexes, the result type and the sequencer states.
// No dependencies; every other file of the block but sgh_ram uses it.
`default_nettype none

package sgh_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  // Field widths.
  localparam int COORD_BITS = 8;
  localparam int KIND_BITS  = 2;
  localparam int MODE_BITS  = 2;
  localparam int CNT_BITS   = 4;
  localparam int SIZE_BITS  = 9;
  localparam int TOL_BITS   = 17;
  localparam int FRAC_BITS  = 16;

  // Configuration port.
  localparam int CFG_AW = 2;
  localparam int CFG_DW = TOL_BITS;

  localparam logic [CFG_AW-1:0] CFG_IDX_WIDTH     = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_IDX_HEIGHT    = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_IDX_TOLERANCE = 2'd2;

  localparam logic [SIZE_BITS-1:0] RST_GRID_WIDTH  = 9'd160;
  localparam logic [SIZE_BITS-1:0] RST_GRID_HEIGHT = 9'd160;
  localparam logic [TOL_BITS-1:0]  RST_TOLERANCE   = 17'd22938;

  // Kinds.
  localparam logic [KIND_BITS-1:0] KIND_A     = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_B     = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_EMPTY = 2'd2;

  // Request modes.
  localparam logic [MODE_BITS-1:0] MODE_WRITE         = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_CHECK_STORED  = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_CHECK_GIVEN   = 2'd2;

  typedef struct packed {
    logic [KIND_BITS-1:0] cell_kind;
    logic                 is_happy;
    logic [CNT_BITS-1:0]  same_count;
    logic [CNT_BITS-1:0]  occupied_count;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_READ,
    S_EVAL,
    S_DONE
  } scan_state_t;

  // Code three reads as empty.
  function automatic logic [KIND_BITS-1:0] norm_kind(input logic [KIND_BITS-1:0] k);
    return (k > KIND_EMPTY) ? KIND_EMPTY : k;
  endfunction

endpackage

`default_nettype wire

// File: src/sgh_req_if.sv
// Request channel: valid/ready handshake with mode, coordinates and kind.
// Depends on sgh_pkg for field widths.
`default_nettype none

interface sgh_req_if;
  logic                                valid;
  logic                                ready;
  logic [sgh_pkg::MODE_BITS-1:0]       mode;
  logic [sgh_pkg::COORD_BITS-1:0]      cell_x;
  logic [sgh_pkg::COORD_BITS-1:0]      cell_y;
  logic [sgh_pkg::KIND_BITS-1:0]       kind;

  modport source (output valid, mode, cell_x, cell_y, kind, input ready);
  modport sink   (input valid, mode, cell_x, cell_y, kind, output ready);
endinterface

`default_nettype wire

// File: src/sgh_rsp_if.sv
// Result channel: valid/ready handshake with stored kind, verdict and counts.
// Depends on sgh_pkg for field widths.
`default_nettype none

interface sgh_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [sgh_pkg::KIND_BITS-1:0]    cell_kind;
  logic                             is_happy;
  logic [sgh_pkg::CNT_BITS-1:0]     same_count;
  logic [sgh_pkg::CNT_BITS-1:0]     occupied_count;

  modport source (output valid, cell_kind, is_happy, same_count, occupied_count, input ready);
  modport sink   (input valid, cell_kind, is_happy, same_count, occupied_count, output ready);
endinterface

`default_nettype wire

// File: src/segregation_grid_happiness_check_core.sv
// Top level of the wrapped housing-grid happiness checker.
// Depends on sgh_pkg, sgh_req_if, sgh_rsp_if, sgh_ram, sgh_coord_mod and sgh_scan.
//
//   Channel   Dir   Handshake          Beat contents
//   in_req    in    valid/ready        mode, cell_x, cell_y, kind
//   out_rsp   out   valid/ready        cell_kind, is_happy, same_count, occupied_count
//   cfg_*     in    cfg_we, no ready   cfg_addr selects width, height or tolerance
//
// Sequence: the coordinates are first reduced when they are outside the grid (8 restoring
//   steps in the coordinate reducer); a check then makes nine reads of the single grid
//   memory read port, one per cycle, and a write or mode-three beat reads only the centre.
// Reset: clears the sequencer and the output register and loads the configuration defaults;
//   the grid is not cleared, and a cell must be written before anything reads it.
// Stalls: the result sits in the output register while the next beat is accepted;
//   a second result waits in the sequencer until that register drains.
`default_nettype none

module segregation_grid_happiness_check_core #(
  parameter int MAX_WIDTH  = sgh_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sgh_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  sgh_req_if.sink                           in_req,
  sgh_rsp_if.source                         out_rsp,
  input  wire logic                         cfg_we,
  input  wire logic [sgh_pkg::CFG_AW-1:0]   cfg_addr,
  input  wire logic [sgh_pkg::CFG_DW-1:0]   cfg_wdata
);
  import sgh_pkg::*;

  localparam int UWW = $clog2(MAX_WIDTH + 1);
  localparam int UHW = $clog2(MAX_HEIGHT + 1);
  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int AW  = XW + YW;

  // Configuration registers.
  logic [SIZE_BITS-1:0] grid_width_r, grid_height_r;
  logic [TOL_BITS-1:0]  tolerance_r;
  logic [UWW-1:0]       used_w;
  logic [UHW-1:0]       used_h;

  // Output register.
  logic out_valid_r, out_valid_nxt;
  rsp_t out_r, out_nxt;

  logic           accept, idle;
  logic           coord_done;
  logic [XW-1:0]  coord_col;
  logic [YW-1:0]  coord_row;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr, mem_raddr;
  logic [KIND_BITS-1:0] mem_wdata, mem_rdata;
  logic           rsp_valid, rsp_take;
  rsp_t           rsp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= RST_GRID_WIDTH;
      grid_height_r <= RST_GRID_HEIGHT;
      tolerance_r   <= RST_TOLERANCE;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_IDX_WIDTH:     grid_width_r  <= cfg_wdata[SIZE_BITS-1:0];
        CFG_IDX_HEIGHT:    grid_height_r <= cfg_wdata[SIZE_BITS-1:0];
        CFG_IDX_TOLERANCE: tolerance_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Clamp the sizes in use: zero acts as one, anything past the maximum as the maximum.
  always_comb begin
    if (grid_width_r == '0) begin
      used_w = UWW'(1);
    end else if (32'(grid_width_r) > MAX_WIDTH) begin
      used_w = UWW'(MAX_WIDTH);
    end else begin
      used_w = UWW'(grid_width_r);
    end
    if (grid_height_r == '0) begin
      used_h = UHW'(1);
    end else if (32'(grid_height_r) > MAX_HEIGHT) begin
      used_h = UHW'(MAX_HEIGHT);
    end else begin
      used_h = UHW'(grid_height_r);
    end
  end

  // Accept a beat only while the sequencer is free.
  assign in_req.ready = idle;
  assign accept       = in_req.valid && idle;

  sgh_coord_mod #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_coord (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (accept),
    .x_in   (in_req.cell_x),
    .y_in   (in_req.cell_y),
    .used_w (used_w),
    .used_h (used_h),
    .done   (coord_done),
    .col    (coord_col),
    .row    (coord_row)
  );

  sgh_scan #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_accept (accept),
    .req_mode   (in_req.mode),
    .req_kind   (in_req.kind),
    .idle       (idle),
    .coord_done (coord_done),
    .coord_col  (coord_col),
    .coord_row  (coord_row),
    .used_w     (used_w),
    .used_h     (used_h),
    .tolerance  (tolerance_r),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata),
    .rsp_valid  (rsp_valid),
    .rsp        (rsp),
    .rsp_take   (rsp_take)
  );

  // Grid store, one 2-bit cell per entry, addressed as {row, col}.
  sgh_ram #(
    .WIDTH (KIND_BITS),
    .DEPTH (2 ** AW)
  ) u_grid (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Load the output register when it is empty or draining this cycle.
  assign rsp_take = rsp_valid && (!out_valid_r || out_rsp.ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (rsp_take) begin
      out_valid_nxt = 1'b1;
      out_nxt       = rsp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_rsp.valid          = out_valid_r;
  assign out_rsp.cell_kind      = out_r.cell_kind;
  assign out_rsp.is_happy       = out_r.is_happy;
  assign out_rsp.same_count     = out_r.same_count;
  assign out_rsp.occupied_count = out_r.occupied_count;

endmodule

`default_nettype wire

// File: src/sgh_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module sgh_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 65536,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: src/sgh_coord_mod.sv
// Coordinate reducer: x mod width and y mod height, one quotient bit per cycle.
// Coordinates already in range skip the restoring steps. Depends on sgh_pkg.
`default_nettype none

module sgh_coord_mod #(
  parameter int MAX_WIDTH  = sgh_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sgh_pkg::DEF_MAX_HEIGHT,
  localparam int UWW = $clog2(MAX_WIDTH + 1),
  localparam int UHW = $clog2(MAX_HEIGHT + 1),
  localparam int XW  = $clog2(MAX_WIDTH),
  localparam int YW  = $clog2(MAX_HEIGHT)
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [sgh_pkg::COORD_BITS-1:0] x_in,
  input  wire logic [sgh_pkg::COORD_BITS-1:0] y_in,
  input  wire logic [UWW-1:0]                 used_w,
  input  wire logic [UHW-1:0]                 used_h,
  output logic                                done,
  output logic      [XW-1:0]                  col,
  output logic      [YW-1:0]                  row
);
  import sgh_pkg::*;

  localparam int CW = $clog2(COORD_BITS + 1);

  logic                  busy_r, busy_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [COORD_BITS-1:0] xd_r, xd_nxt, yd_r, yd_nxt;
  logic [UWW-1:0]        xr_r, xr_nxt;
  logic [UHW-1:0]        yr_r, yr_nxt;
  logic [UWW:0]          xs;
  logic [UHW:0]          ys;

  assign done = busy_r && (cnt_r == '0);
  assign col  = XW'(xr_r);
  assign row  = YW'(yr_r);

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    xd_nxt   = xd_r;
    yd_nxt   = yd_r;
    xr_nxt   = xr_r;
    yr_nxt   = yr_r;
    xs = {xr_r, xd_r[COORD_BITS-1]};
    ys = {yr_r, yd_r[COORD_BITS-1]};
    if (start) begin
      busy_nxt = 1'b1;
      xd_nxt   = x_in;
      yd_nxt   = y_in;
      if ((32'(x_in) < 32'(used_w)) && (32'(y_in) < 32'(used_h))) begin
        xr_nxt  = UWW'(x_in);
        yr_nxt  = UHW'(y_in);
        cnt_nxt = '0;
      end else begin
        xr_nxt  = '0;
        yr_nxt  = '0;
        cnt_nxt = CW'(COORD_BITS);
      end
    end else if (done) begin
      busy_nxt = 1'b0;
    end else if (busy_r) begin
      // One restoring step on each axis.
      xr_nxt  = UWW'((xs >= {1'b0, used_w}) ? xs - {1'b0, used_w} : xs);
      yr_nxt  = UHW'((ys >= {1'b0, used_h}) ? ys - {1'b0, used_h} : ys);
      xd_nxt  = {xd_r[COORD_BITS-2:0], 1'b0};
      yd_nxt  = {yd_r[COORD_BITS-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    xd_r <= xd_nxt;
    yd_r <= yd_nxt;
    xr_r <= xr_nxt;
    yr_r <= yr_nxt;
  end

endmodule

`default_nettype wire

// File: src/sgh_scan.sv
// Sequencer: reads the centre and, for a check, eight wrapped neighbors from the grid
// memory, counts the neighbors, writes cells and forms the verdict. Depends on sgh_pkg.
`default_nettype none

module sgh_scan #(
  parameter int MAX_WIDTH  = sgh_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sgh_pkg::DEF_MAX_HEIGHT,
  localparam int UWW = $clog2(MAX_WIDTH + 1),
  localparam int UHW = $clog2(MAX_HEIGHT + 1),
  localparam int XW  = $clog2(MAX_WIDTH),
  localparam int YW  = $clog2(MAX_HEIGHT),
  localparam int AW  = XW + YW
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          req_accept,
  input  wire logic [sgh_pkg::MODE_BITS-1:0] req_mode,
  input  wire logic [sgh_pkg::KIND_BITS-1:0] req_kind,
  output logic                               idle,
  input  wire logic                          coord_done,
  input  wire logic [XW-1:0]                 coord_col,
  input  wire logic [YW-1:0]                 coord_row,
  input  wire logic [UWW-1:0]                used_w,
  input  wire logic [UHW-1:0]                used_h,
  input  wire logic [sgh_pkg::TOL_BITS-1:0]  tolerance,
  output logic                               mem_we,
  output logic      [AW-1:0]                 mem_waddr,
  output logic      [sgh_pkg::KIND_BITS-1:0] mem_wdata,
  output logic      [AW-1:0]                 mem_raddr,
  input  wire logic [sgh_pkg::KIND_BITS-1:0] mem_rdata,
  output logic                               rsp_valid,
  output sgh_pkg::rsp_t                      rsp,
  input  wire logic                          rsp_take
);
  import sgh_pkg::*;

  localparam int NB_READS = 9;
  localparam int IW = $clog2(NB_READS + 1);

  scan_state_t          state_r, state_nxt;
  logic [MODE_BITS-1:0] mode_r, mode_nxt;
  logic [KIND_BITS-1:0] kind_r, kind_nxt, me_r, me_nxt, stored_r, stored_nxt;
  logic [XW-1:0]        col_r, col_nxt, colm_r, colm_nxt, colp_r, colp_nxt;
  logic [YW-1:0]        row_r, row_nxt, rowm_r, rowm_nxt, rowp_r, rowp_nxt;
  logic [IW-1:0]        idx_r, idx_nxt;
  logic [CNT_BITS-1:0]  same_r, same_nxt, occ_r, occ_nxt;
  rsp_t                 rsp_r, rsp_nxt;
  logic                 is_check;
  logic [UWW-1:0]       col_inc;
  logic [UHW-1:0]       row_inc;
  logic [TOL_BITS+CNT_BITS-1:0] need;
  logic [TOL_BITS+CNT_BITS-1:0] have;
  logic [XW-1:0]        rcol;
  logic [YW-1:0]        rrow;

  assign is_check  = (mode_r == MODE_CHECK_STORED) || (mode_r == MODE_CHECK_GIVEN);
  assign col_inc   = UWW'(coord_col) + 1'b1;
  assign row_inc   = UHW'(coord_row) + 1'b1;
  assign need      = tolerance * occ_r;
  assign have      = (TOL_BITS + CNT_BITS)'({same_r, {FRAC_BITS{1'b0}}});
  assign mem_waddr = {row_r, col_r};
  assign mem_wdata = kind_r;
  assign mem_raddr = {rrow, rcol};
  assign rsp       = rsp_r;
  assign idle      = (state_r == S_IDLE);

  // Read order: centre, then the row above, the two sides, the row below.
  always_comb begin
    case (idx_r)
      IW'(1): begin rcol = colm_r; rrow = rowm_r; end
      IW'(2): begin rcol = col_r;  rrow = rowm_r; end
      IW'(3): begin rcol = colp_r; rrow = rowm_r; end
      IW'(4): begin rcol = colm_r; rrow = row_r;  end
      IW'(5): begin rcol = colp_r; rrow = row_r;  end
      IW'(6): begin rcol = colm_r; rrow = rowp_r; end
      IW'(7): begin rcol = col_r;  rrow = rowp_r; end
      IW'(8): begin rcol = colp_r; rrow = rowp_r; end
      default: begin rcol = col_r; rrow = row_r; end
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    kind_nxt   = kind_r;
    me_nxt     = me_r;
    stored_nxt = stored_r;
    col_nxt    = col_r;
    colm_nxt   = colm_r;
    colp_nxt   = colp_r;
    row_nxt    = row_r;
    rowm_nxt   = rowm_r;
    rowp_nxt   = rowp_r;
    idx_nxt    = idx_r;
    same_nxt   = same_r;
    occ_nxt    = occ_r;
    rsp_nxt    = rsp_r;
    mem_we     = 1'b0;
    rsp_valid  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (req_accept) begin
          mode_nxt  = req_mode;
          kind_nxt  = norm_kind(req_kind);
          same_nxt  = '0;
          occ_nxt   = '0;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        if (coord_done) begin
          col_nxt   = coord_col;
          row_nxt   = coord_row;
          colm_nxt  = (coord_col == '0) ? XW'(used_w - 1'b1) : coord_col - 1'b1;
          rowm_nxt  = (coord_row == '0) ? YW'(used_h - 1'b1) : coord_row - 1'b1;
          colp_nxt  = (col_inc >= used_w) ? '0 : XW'(col_inc);
          rowp_nxt  = (row_inc >= used_h) ? '0 : YW'(row_inc);
          idx_nxt   = '0;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        idx_nxt = idx_r + 1'b1;
        if (idx_r == IW'(1)) begin
          stored_nxt = mem_rdata;
          me_nxt = (mode_r == MODE_CHECK_STORED) ? norm_kind(mem_rdata) : kind_r;
          mem_we = (mode_r == MODE_WRITE);
          if (!is_check) begin
            state_nxt = S_EVAL;
          end
        end else if (idx_r != '0) begin
          if (mem_rdata < KIND_EMPTY) begin
            occ_nxt = occ_r + 1'b1;
            if (mem_rdata == me_r) begin
              same_nxt = same_r + 1'b1;
            end
          end
          if (idx_r == IW'(NB_READS)) begin
            state_nxt = S_EVAL;
          end
        end
      end
      S_EVAL: begin
        rsp_nxt.cell_kind      = stored_r;
        rsp_nxt.is_happy       = is_check && ((occ_r == '0) || (have >= need));
        rsp_nxt.same_count     = is_check ? same_r : '0;
        rsp_nxt.occupied_count = is_check ? occ_r : '0;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        rsp_valid = 1'b1;
        if (rsp_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
    mode_r   <= mode_nxt;
    kind_r   <= kind_nxt;
    me_r     <= me_nxt;
    stored_r <= stored_nxt;
    col_r    <= col_nxt;
    colm_r   <= colm_nxt;
    colp_r   <= colp_nxt;
    row_r    <= row_nxt;
    rowm_r   <= rowm_nxt;
    rowp_r   <= rowp_nxt;
    same_r   <= same_nxt;
    occ_r    <= occ_nxt;
    rsp_r    <= rsp_nxt;
  end

endmodule

`default_nettype wire
